// File: hw/rtl/tbt_pkg.sv
// Shared widths and constants for the barycentric point-in-triangle block.
// No dependencies; imported by triangle_barycentric_test.
package tbt_pkg;

  localparam int CRD_W = 16;
  localparam int PIX_W = 12;
  localparam int W_W   = 18;
  localparam int MA_W  = 16;

  localparam logic [MA_W-1:0]       MIN_AREA_RST = 16'd2;
  localparam logic signed [W_W-1:0] W_MAX = {1'b0, {(W_W-1){1'b1}}};
  localparam logic signed [W_W-1:0] W_MIN = {1'b1, {(W_W-1){1'b0}}};

endpackage

// File: hw/rtl/triangle_barycentric_test.sv
// Barycentric point-in-triangle test, fully pipelined with restoring dividers.
// Depends on tbt_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one word: vertices A, B, C in
//   signed Q12.4 and an integer pixel (px, py). Output channel
//   out_valid/out_ready returns one word per input: inside_res, degenerate
//   and the weights w_a, w_b, w_c in signed Q4.14, rounded and saturated.
//   Config channel cfg_valid/cfg_ready writes min_area; cfg_ready is always
//   high. Write it only while the pipeline is empty.
// Pipeline: difference, multiply, cross product, magnitude and numerator
//   stages, one quotient bit per divider stage, then the saturating output
//   register.
// Throughput: one word per cycle while the output is not stalled; the
//   three weight dividers are bit-serial across stages, one stage per
//   quotient bit.
// Reset: all stage valid bits clear, min_area returns to 2.
// Stall: each stage holds while its successor is full and stalled; empty
//   stages keep filling, so in_ready stays high until the pipeline is full.
module triangle_barycentric_test
  import tbt_pkg::*;
#(
  parameter int COORD_FRAC_BITS  = 4,
  parameter int WEIGHT_FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [MA_W-1:0]         cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [CRD_W-1:0] ax,
  input  logic signed [CRD_W-1:0] ay,
  input  logic signed [CRD_W-1:0] bx,
  input  logic signed [CRD_W-1:0] by_coord,
  input  logic signed [CRD_W-1:0] cx,
  input  logic signed [CRD_W-1:0] cy,
  input  logic signed [PIX_W-1:0] px,
  input  logic signed [PIX_W-1:0] py,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    inside_res,
  output logic                    degenerate,
  output logic signed [W_W-1:0]   w_a,
  output logic signed [W_W-1:0]   w_b,
  output logic signed [W_W-1:0]   w_c
);

  localparam int PW   = ((CRD_W > PIX_W + COORD_FRAC_BITS) ? CRD_W
                                                             : PIX_W + COORD_FRAC_BITS) + 1;
  localparam int PRW  = 2 * PW;
  localparam int UW   = PRW + 1;
  localparam int NAW  = PRW + 3;
  localparam int DW   = UW;
  localparam int NUMW = NAW + WEIGHT_FRAC_BITS + 1;
  localparam int QW   = W_W;
  localparam int CW   = NUMW + QW;
  localparam int NS   = QW + 6;
  localparam logic [QW-1:0] Q_HALF = {1'b1, {(QW-1){1'b0}}};
  localparam logic [QW-1:0] Q_MAX  = {1'b0, {(QW-1){1'b1}}};

  typedef struct packed {
    logic signed [PW-1:0] abx, aby, acx, acy, pax, pay;
  } dif_t;

  typedef struct packed {
    logic signed [PRW-1:0] p1, p2, p3, p4, p5, p6;
  } prd_t;

  typedef struct packed {
    logic signed [UW-1:0] ux, uy, uz;
  } crs_t;

  typedef struct packed {
    logic [2:0][NAW-1:0] an;
    logic [DW-1:0]       ad;
    logic [2:0]          neg;
    logic                degen;
    logic                in_tri;
  } mag_t;

  typedef struct packed {
    logic [2:0][CW-1:0] rem;
    logic [2:0][QW-1:0] q;
    logic [2:0]         ovf;
    logic [2:0]         neg;
    logic [DW-1:0]      ad;
    logic               degen;
    logic               in_tri;
  } div_t;

  logic [MA_W-1:0] min_area;
  logic [NS-1:0]   v;
  logic [NS-1:0]   vin;
  logic [NS:0]     rdy;
  logic [NS-1:0]   load;

  dif_t dif, dif_next;
  prd_t prd, prd_next;
  crs_t crs, crs_next;
  mag_t mg, mg_next;
  div_t dv [QW+1];
  div_t dv_next [QW+1];

  logic signed [W_W-1:0] w_next [3];
  logic signed [NAW-1:0] nv [3];
  logic [2:0]            nonneg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_area <= MIN_AREA_RST;
    end else if (cfg_valid) begin
      min_area <= cfg_data;
    end
  end

  // stage handshake: a stage loads when empty or when its word moves on
  assign rdy[NS] = out_ready;
  assign vin     = {v[NS-2:0], in_valid};
  assign load    = vin & rdy[NS-1:0];
  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];

  genvar gs;
  generate
    for (gs = 0; gs < NS; gs++) begin : g_rdy
      assign rdy[gs] = !v[gs] || rdy[gs+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) v[s] <= vin[s];
      end
    end
  end

  // edge and pixel differences
  always_comb begin
    logic signed [PW-1:0] axe, aye, bxe, bye, cxe, cye, pxs, pys;
    axe = PW'(ax);
    aye = PW'(ay);
    bxe = PW'(bx);
    bye = PW'(by_coord);
    cxe = PW'(cx);
    cye = PW'(cy);
    pxs = PW'(px) <<< COORD_FRAC_BITS;
    pys = PW'(py) <<< COORD_FRAC_BITS;
    dif_next.abx = bxe - axe;
    dif_next.aby = bye - aye;
    dif_next.acx = cxe - axe;
    dif_next.acy = cye - aye;
    dif_next.pax = axe - pxs;
    dif_next.pay = aye - pys;
  end

  always_comb begin
    prd_next.p1 = PRW'(dif.abx) * PRW'(dif.pay);
    prd_next.p2 = PRW'(dif.pax) * PRW'(dif.aby);
    prd_next.p3 = PRW'(dif.pax) * PRW'(dif.acy);
    prd_next.p4 = PRW'(dif.acx) * PRW'(dif.pay);
    prd_next.p5 = PRW'(dif.acx) * PRW'(dif.aby);
    prd_next.p6 = PRW'(dif.abx) * PRW'(dif.acy);
  end

  always_comb begin
    crs_next.ux = UW'(prd.p1) - UW'(prd.p2);
    crs_next.uy = UW'(prd.p3) - UW'(prd.p4);
    crs_next.uz = UW'(prd.p5) - UW'(prd.p6);
  end

  // lanes: 0 = weight of A, 1 = weight of B, 2 = weight of C
  always_comb begin
    nv[0] = NAW'(crs.uz) - NAW'(crs.ux) - NAW'(crs.uy);
    nv[1] = NAW'(crs.uy);
    nv[2] = NAW'(crs.ux);
    mg_next.ad = crs.uz[UW-1] ? DW'(-crs.uz) : DW'(crs.uz);
    for (int l = 0; l < 3; l++) begin
      mg_next.an[l]  = nv[l][NAW-1] ? NAW'(-nv[l]) : NAW'(nv[l]);
      mg_next.neg[l] = nv[l][NAW-1] ^ crs.uz[UW-1];
      nonneg[l]      = (nv[l] == '0) || !mg_next.neg[l];
    end
    mg_next.degen  = mg_next.ad <= DW'(min_area);
    mg_next.in_tri = !mg_next.degen && (&nonneg);
  end

  // rounded numerator and overflow check
  always_comb begin
    dv_next[0].ad     = mg.ad;
    dv_next[0].neg    = mg.neg;
    dv_next[0].degen  = mg.degen;
    dv_next[0].in_tri = mg.in_tri;
    dv_next[0].q      = '0;
    for (int l = 0; l < 3; l++) begin
      dv_next[0].rem[l] = (CW'(mg.an[l]) << WEIGHT_FRAC_BITS) + CW'(mg.ad >> 1);
      dv_next[0].ovf[l] = dv_next[0].rem[l] >= (CW'(mg.ad) << QW);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < QW; gi++) begin : g_div
      localparam int B = QW - 1 - gi;
      always_comb begin
        logic [CW-1:0] sub;
        sub = CW'(dv[gi].ad) << B;
        dv_next[gi+1] = dv[gi];
        for (int l = 0; l < 3; l++) begin
          if (dv[gi].rem[l] >= sub) begin
            dv_next[gi+1].rem[l]  = dv[gi].rem[l] - sub;
            dv_next[gi+1].q[l][B] = 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (load[gi+5]) dv[gi+1] <= dv_next[gi+1];
      end
    end
  endgenerate

  // saturate, sign and zero degenerate
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv[QW].degen) begin
        w_next[l] = '0;
      end else if (dv[QW].neg[l]) begin
        if (dv[QW].ovf[l] || dv[QW].q[l] > Q_HALF) w_next[l] = W_MIN;
        else w_next[l] = -$signed(dv[QW].q[l]);
      end else begin
        if (dv[QW].ovf[l] || dv[QW].q[l] > Q_MAX) w_next[l] = W_MAX;
        else w_next[l] = $signed(dv[QW].q[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) dif <= dif_next;
    if (load[1]) prd <= prd_next;
    if (load[2]) crs <= crs_next;
    if (load[3]) mg <= mg_next;
    if (load[4]) dv[0] <= dv_next[0];
    if (load[NS-1]) begin
      w_a        <= w_next[0];
      w_b        <= w_next[1];
      w_c        <= w_next[2];
      degenerate <= dv[QW].degen;
      inside_res <= dv[QW].in_tri;
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> !inside_res && w_a == '0 && w_b == '0 && w_c == '0)
    else $error("degenerate word with nonzero weights");

  a_inside_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && inside_res |-> !w_a[W_W-1] && !w_b[W_W-1] && !w_c[W_W-1])
    else $error("inside word with negative weight");

  a_no_block: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input blocked while output drains");

  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    v[NS-2] && !dv[QW].degen && dv[QW].ovf[1] && rdy[NS-1] |=>
      (w_b == W_MAX || w_b == W_MIN))
    else $error("overflowed weight not saturated");

endmodule

// File: bench/tb_triangle_barycentric_test.sv
// Self-checking bench for triangle_barycentric_test: barycentric weights and inside flag.
// Uses a small scoreboard class holding predicted words; depends on tbt_pkg and the DUT.
module tb_triangle_barycentric_test;
  import tbt_pkg::*;

  typedef struct packed {
    logic                  in_tri;
    logic                  degen;
    logic signed [W_W-1:0] wa;
    logic signed [W_W-1:0] wb;
    logic signed [W_W-1:0] wc;
  } weights_t;

  class weight_board;
    weights_t pending[$];
    int       errors;
    logic [MA_W-1:0] min_area;

    function longint quot(longint n, longint d);
      longint an, ad, q;
      an = n < 0 ? -n : n;
      ad = d < 0 ? -d : d;
      q = ((an <<< 14) + ad / 2) / ad;
      if ((n < 0) != (d < 0)) return (q > 131072) ? -131072 : -q;
      return (q > 131071) ? 131071 : q;
    endfunction

    function bit sign_ok(longint n, longint d);
      return n == 0 || ((n < 0) == (d < 0));
    endfunction

    function void note_input(logic signed [CRD_W-1:0] ax, ay, bx, by, cx, cy,
                             logic signed [PIX_W-1:0] px, py);
      longint pxs, pys, acx, abx, pax, acy, aby, pay, ux, uy, uz, na;
      weights_t e;
      pxs = longint'(px) * 16;
      pys = longint'(py) * 16;
      acx = longint'(cx) - ax; abx = longint'(bx) - ax; pax = longint'(ax) - pxs;
      acy = longint'(cy) - ay; aby = longint'(by) - ay; pay = longint'(ay) - pys;
      ux = abx * pay - pax * aby;
      uy = pax * acy - acx * pay;
      uz = acx * aby - abx * acy;
      na = uz - ux - uy;
      e = '0;
      if ((uz < 0 ? -uz : uz) <= longint'(min_area)) begin
        e.degen = 1'b1;
      end else begin
        e.wa = W_W'(quot(na, uz));
        e.wb = W_W'(quot(uy, uz));
        e.wc = W_W'(quot(ux, uz));
        e.in_tri = sign_ok(na, uz) && sign_ok(uy, uz) && sign_ok(ux, uz);
      end
      pending.push_back(e);
    endfunction

    function void check_result(weights_t got);
      weights_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.in_tri !== e.in_tri) begin
        $error("inside_res exp %0d got %0d", e.in_tri, got.in_tri); errors++;
      end
      if (got.degen !== e.degen) begin
        $error("degenerate exp %0d got %0d", e.degen, got.degen); errors++;
      end
      if (got.wa !== e.wa) begin
        $error("w_a exp %0d got %0d", e.wa, got.wa); errors++;
      end
      if (got.wb !== e.wb) begin
        $error("w_b exp %0d got %0d", e.wb, got.wb); errors++;
      end
      if (got.wc !== e.wc) begin
        $error("w_c exp %0d got %0d", e.wc, got.wc); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [MA_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [CRD_W-1:0] ax, ay, bx, by_coord, cx, cy;
  logic signed [PIX_W-1:0] px, py;
  logic inside_res, degenerate;
  logic signed [W_W-1:0] w_a, w_b, w_c;

  weight_board board;
  int send_idle, recv_idle, stuck;

  triangle_barycentric_test dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data, .in_valid, .in_ready,
    .ax, .ay, .bx, .by_coord, .cx, .cy, .px, .py, .out_valid, .out_ready,
    .inside_res, .degenerate, .w_a, .w_b, .w_c
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1'b1; cfg_valid = 1'b0; cfg_data = '0; in_valid = 1'b0;
    {ax, ay, bx, by_coord, cx, cy} = '0;
    px = '0; py = '0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        board.check_result('{inside_res, degenerate, w_a, w_b, w_c});
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck > 20000) begin
        $display("triangle_barycentric_test test failed");
        $finish;
      end
    end
  end

  task automatic write_min_area(logic [MA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.min_area = v;
  endtask

  task automatic send_tri(logic signed [CRD_W-1:0] a_x, a_y, b_x, b_y, c_x, c_y,
                          logic signed [PIX_W-1:0] p_x, p_y);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ax <= a_x; ay <= a_y; bx <= b_x; by_coord <= b_y; cx <= c_x; cy <= c_y;
    px <= p_x; py <= p_y;
    do @(posedge clk); while (!in_ready);
    board.note_input(a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic random_tris(int count);
    logic signed [CRD_W-1:0] v[6];
    logic signed [PIX_W-1:0] p_x, p_y;
    int span;
    repeat (count) begin
      case ($urandom_range(3))
        0: span = 16;
        1: span = 400;
        2: span = 4000;
        default: span = 32767;
      endcase
      foreach (v[i]) v[i] = CRD_W'($signed($urandom_range(2 * span)) - span);
      if ($urandom_range(9) == 0) v[4] = v[2];
      if ($urandom_range(9) == 0) begin
        v[4] = v[0]; v[5] = v[1];
      end
      if ($urandom_range(3) == 0) begin
        p_x = PIX_W'($urandom); p_y = PIX_W'($urandom);
      end else begin
        p_x = PIX_W'((v[$urandom_range(2) * 2] >>> 4) + $signed($urandom_range(20)) - 10);
        p_y = PIX_W'((v[$urandom_range(2) * 2 + 1] >>> 4) + $signed($urandom_range(20)) - 10);
      end
      send_tri(v[0], v[1], v[2], v[3], v[4], v[5], p_x, p_y);
    end
  endtask

  initial begin
    board = new();
    board.min_area = MIN_AREA_RST;
    send_idle = 22; recv_idle = 45;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_tri(0, 0, 160, 0, 0, 160, 2, 2);
    send_tri(0, 0, 160, 0, 0, 160, 20, 20);
    send_tri(0, 0, 160, 0, 0, 160, 0, 0);
    send_tri(0, 0, 160, 0, 0, 160, 5, 5);
    send_tri(0, 0, 160, 160, 320, 320, 3, 3);
    send_tri(5, 5, 5, 5, 5, 5, 0, 0);
    send_tri(0, 0, 1, 0, 0, 1, 0, 0);
    send_tri(0, 0, 1, 0, 0, 2, 0, 0);
    send_tri(0, 0, 1, 0, 0, 3, -2048, 2047);
    send_tri(-32768, -32768, 32767, -32768, -32768, 32767, 2047, 2047);
    send_tri(32767, 32767, -32768, 32767, 32767, -32768, -2048, -2048);
    send_tri(0, 0, 16, 0, 0, 16, 2047, -2048);
    send_tri(-32768, 32767, 32767, 32767, 0, -32768, 0, 0);
    send_tri(0, 0, 48, 0, 0, 48, 1, 1);
    send_tri(0, 0, 32, 0, 0, 32, -1, 0);
    drain();

    write_min_area(16'd0);
    random_tris(150);
    drain();
    write_min_area(16'hFFFF);
    random_tris(150);
    drain();
    send_idle = 45; recv_idle = 22;
    write_min_area(MA_W'($urandom));
    random_tris(350);
    drain();
    send_idle = 0; recv_idle = 0;
    write_min_area(16'd2);
    random_tris(700);
    drain();

    if (board.errors == 0 && board.pending.size() == 0)
      $display("triangle_barycentric_test test passed");
    else
      $display("triangle_barycentric_test test failed");
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/tbt_pkg.sv
hw/rtl/triangle_barycentric_test.sv
bench/tb_triangle_barycentric_test.sv
